@@ rtl/tpe_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tpe_pkg
// Shared types, command codes and tables of the tracker pitch effect unit.
// ---------------------------------------------------------------------------
package tpe_pkg;

  typedef enum logic [2:0] {
    FUNC_NOTE_ON  = 3'd0,
    FUNC_SLIDE_UP = 3'd1,
    FUNC_SLIDE_DN = 3'd2,
    FUNC_PORTA_TG = 3'd3,
    FUNC_PORTA_ST = 3'd4,
    FUNC_VIBRATO  = 3'd5,
    FUNC_ARPEGGIO = 3'd6,
    FUNC_KEY_OFF  = 3'd7
  } func_e;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_NOTE_ON,
    OP_SLIDE_UP,
    OP_SLIDE_DN,
    OP_PORTA_TG,
    OP_PORTA_CMP,
    OP_PORTA_UP,
    OP_PORTA_DN,
    OP_VIB_STEP,
    OP_ARP,
    OP_KEY_OFF,
    OP_STORE,
    OP_POST
  } op_e;

  typedef struct packed {
    op_e op;
  } tpe_cmd_t;

  typedef struct packed {
    logic cur_lt_tgt;
    logic cur_gt_tgt;
    logic vib_active;
    logic vib_last;
    logic chan_ok;
    logic [2:0] func;
  } tpe_status_t;

  localparam logic [10:0] FNUM_HIGH = 11'd686;
  localparam logic [10:0] FNUM_LOW  = 11'd342;
  localparam logic [6:0]  NOTE_KEY_OFF = 7'd127;
  localparam logic [6:0]  NOTE_MAX  = 7'd96;

  function automatic logic [9:0] note_fnum(input logic [3:0] idx);
    logic [9:0] r;
    case (idx)
      4'd0: r = 10'd340;  4'd1: r = 10'd363;  4'd2: r = 10'd385;
      4'd3: r = 10'd408;  4'd4: r = 10'd432;  4'd5: r = 10'd458;
      4'd6: r = 10'd485;  4'd7: r = 10'd514;  4'd8: r = 10'd544;
      4'd9: r = 10'd577;  4'd10: r = 10'd611; default: r = 10'd647;
    endcase
    return r;
  endfunction

  // Triangle wave, entries 0..31.
  function automatic logic [4:0] vib_wave(input logic [4:0] idx);
    logic [4:0] r;
    if (idx[4]) r = 5'd16 - {1'b0, idx[3:0]};
    else r = {1'b0, idx[3:0]} + 5'd1;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/tpe_ctrl.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tpe_ctrl
// Sequencer: steps one command through the datapath operations.
// ---------------------------------------------------------------------------
module tpe_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  input  wire tpe_pkg::tpe_status_t status_i,
  output tpe_pkg::tpe_cmd_t        cmd_o
);
  import tpe_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_PORTA2, S_VIB, S_STORE, S_OUT
  } state_e;

  state_e state_q;
  logic   pend_q, pend_d;
  logic   post;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = pend_q;

  // result moves into the output register once the previous one is gone
  assign post = (state_q == S_OUT) && (!pend_q || out_ready_i);

  always_comb begin
    pend_d = pend_q;
    if (pend_q && out_ready_i) pend_d = 1'b0;
    if (post) pend_d = 1'b1;
  end

  always_comb begin
    cmd_o.op = OP_IDLE;
    unique case (state_q)
      S_IDLE: if (in_valid_i) cmd_o.op = OP_LOAD;
      S_DISPATCH: begin
        if (!status_i.chan_ok) cmd_o.op = OP_IDLE;
        else begin
          case (status_i.func)
            FUNC_NOTE_ON:  cmd_o.op = OP_NOTE_ON;
            FUNC_SLIDE_UP: cmd_o.op = OP_SLIDE_UP;
            FUNC_SLIDE_DN: cmd_o.op = OP_SLIDE_DN;
            FUNC_PORTA_TG: cmd_o.op = OP_PORTA_TG;
            FUNC_PORTA_ST: cmd_o.op = status_i.cur_lt_tgt ? OP_PORTA_UP : OP_PORTA_CMP;
            FUNC_VIBRATO:  cmd_o.op = OP_IDLE;
            FUNC_ARPEGGIO: cmd_o.op = OP_ARP;
            default:       cmd_o.op = OP_KEY_OFF;
          endcase
        end
      end
      S_PORTA2: if (status_i.cur_gt_tgt) cmd_o.op = OP_PORTA_DN;
      S_VIB:    cmd_o.op = OP_VIB_STEP;
      S_STORE:  cmd_o.op = OP_STORE;
      S_OUT:    if (post) cmd_o.op = OP_POST;
      default:  cmd_o.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
    end else begin
      pend_q <= pend_d;
      unique case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_DISPATCH;
        S_DISPATCH: begin
          if (!status_i.chan_ok) state_q <= S_STORE;
          else if (status_i.func == FUNC_PORTA_ST) state_q <= S_PORTA2;
          else if (status_i.func == FUNC_VIBRATO)
            state_q <= status_i.vib_active ? S_VIB : S_STORE;
          else state_q <= S_STORE;
        end
        S_PORTA2: state_q <= S_STORE;
        S_VIB:    if (status_i.vib_last) state_q <= S_STORE;
        S_STORE:  state_q <= S_OUT;
        S_OUT:    if (post) state_q <= S_IDLE;
        default:  state_q <= S_IDLE;
      endcase
    end
  end
endmodule

`default_nettype wire

@@ rtl/tpe_datapath.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tpe_datapath
// Per-channel pitch state and the working registers of one command.
// ---------------------------------------------------------------------------
module tpe_datapath #(
  parameter int CHANNELS = 9
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tpe_pkg::tpe_cmd_t   cmd_i,
  output tpe_pkg::tpe_status_t     status_o,
  input  wire logic [2:0]          func_i,
  input  wire logic [3:0]          channel_sel_i,
  input  wire logic [6:0]          note_value_i,
  input  wire logic [7:0]          slide_amount_i,
  input  wire logic signed [7:0]   pre_slide_i,
  input  wire logic [3:0]          vib_speed_i,
  input  wire logic [3:0]          vib_depth_i,
  input  wire logic [3:0]          arp_first_i,
  input  wire logic [3:0]          arp_second_i,
  output logic [3:0]               out_channel_o,
  output logic [7:0]               fnum_low_o,
  output logic [5:0]               block_key_byte_o
);
  import tpe_pkg::*;

  localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [9:0] fnum_m  [CHANNELS];
  logic [2:0] blk_m   [CHANNELS];
  logic       key_m   [CHANNELS];
  logic [9:0] tfnum_m [CHANNELS];
  logic [2:0] tblk_m  [CHANNELS];
  logic [5:0] phase_m [CHANNELS];
  logic [6:0] bnote_m [CHANNELS];

  // working copy
  logic [2:0] func_q;
  logic [3:0] ch_q;
  logic [6:0] note_q;
  logic [7:0] amt_q;
  logic signed [7:0] det_q;
  logic [3:0] a1_q, a2_q, vcnt_q, div_q;
  logic [9:0] f_q, tf_q;
  logic [2:0] b_q, tb_q;
  logic       k_q;
  logic [5:0] ph_q;
  logic [6:0] bn_q;
  logic [7:0] lo_q;
  logic [5:0] bk_q;

  logic chan_ok;
  assign chan_ok = ({28'd0, ch_q} < CHANNELS);
  logic [IW-1:0] ci, ld_ci;
  assign ci    = ch_q[IW-1:0];
  assign ld_ci = channel_sel_i[IW-1:0];

  logic [12:0] cur_pos, tgt_pos;
  assign cur_pos = {b_q, f_q};
  assign tgt_pos = {tb_q, tf_q};

  // slide primitives
  function automatic logic [12:0] up_f(input logic [9:0] f, input logic [2:0] b,
                                       input logic [7:0] a);
    logic [10:0] s;
    s = {1'b0, f} + {3'd0, a};
    if (s >= FNUM_HIGH) begin
      if (b < 3'd7) return {b + 3'd1, s[10:1]};
      else return {b, FNUM_HIGH[9:0]};
    end
    return {b, s[9:0]};
  endfunction

  function automatic logic [12:0] dn_f(input logic [9:0] f, input logic [2:0] b,
                                       input logic [7:0] a);
    logic [10:0] s;
    s = ({3'd0, a} > {1'b0, f}) ? 11'd0 : ({1'b0, f} - {3'd0, a});
    if (s <= FNUM_LOW) begin
      if (b != 3'd0) return {b - 3'd1, s[8:0], 1'b0};
      else return {b, FNUM_LOW[9:0]};
    end
    return {b, s[9:0]};
  endfunction

  // note lookup: returns fnum/block for note 1..96; octave by parallel
  // compares against multiples of 12
  function automatic logic [12:0] look(input logic [7:0] n, input logic signed [7:0] d);
    logic [7:0] m, r;
    logic [2:0] q;
    logic [9:0] f;
    m = (n == 8'd0) ? 8'd0 : ((n > {1'b0, NOTE_MAX}) ? 8'd95 : n - 8'd1);
    q = 3'd0;
    for (int k = 1; k < 8; k++) begin
      if (m >= 8'(12 * k)) q = 3'(k);
    end
    r = m - ({2'd0, q, 3'd0} + {3'd0, q, 2'd0});
    f = note_fnum(r[3:0]) + {{2{d[7]}}, d};
    return {q, f};
  endfunction

  // vibrato step
  logic [5:0] pn;
  logic [4:0] widx, wv, vamt;
  assign pn = ph_q + 6'd1;
  always_comb begin
    if (pn < 6'd16) widx = pn[4:0] + 5'd16;
    else if (pn < 6'd48) widx = 5'(pn - 6'd16);
    else widx = 5'(pn - 6'd48);
    wv = vib_wave(widx);
    // wave / divisor: quotient is at most 8 since the divisor is 2 or more
    vamt = 5'd0;
    for (int k = 1; k <= 8; k++) begin
      if ({3'd0, wv} >= 8'(k) * {4'd0, div_q}) vamt = 5'(k);
    end
  end

  logic [7:0] arp_n;
  logic [1:0] arp_p;
  always_comb begin
    arp_p = (ph_q < 6'd2) ? 2'(ph_q + 6'd1) : 2'd0;
    case (arp_p)
      2'd0: arp_n = {1'b0, bn_q};
      2'd1: arp_n = {1'b0, bn_q} + {4'd0, a1_q};
      default: arp_n = {1'b0, bn_q} + {4'd0, a2_q};
    endcase
  end

  logic [12:0] r_up, r_dn, r_vu, r_vd, r_nt, r_ar, r_tg;
  assign r_up = up_f(f_q, b_q, amt_q);
  assign r_dn = dn_f(f_q, b_q, amt_q);
  assign r_vu = up_f(f_q, b_q, {3'd0, vamt});
  assign r_vd = dn_f(f_q, b_q, {3'd0, vamt});
  assign r_nt = look({1'b0, note_q}, det_q);
  assign r_tg = look({1'b0, note_q}, 8'sd0);
  assign r_ar = look((arp_n == 8'd0) ? 8'd1 : arp_n, det_q);

  logic vup;
  assign vup = (pn < 6'd16) || (pn >= 6'd48);

  assign status_o.cur_lt_tgt = cur_pos < tgt_pos;
  assign status_o.cur_gt_tgt = cur_pos > tgt_pos;
  assign status_o.vib_active = (vcnt_q != 4'd0) && (div_q != 4'd0);
  assign status_o.vib_last   = (vcnt_q == 4'd1);
  assign status_o.chan_ok    = chan_ok;
  assign status_o.func       = func_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        fnum_m[c] <= '0; blk_m[c] <= '0; key_m[c] <= 1'b0; tfnum_m[c] <= '0;
        tblk_m[c] <= '0; phase_m[c] <= '0; bnote_m[c] <= '0;
      end
    end else if (cmd_i.op == OP_STORE && chan_ok) begin
      fnum_m[ci] <= f_q; blk_m[ci] <= b_q; key_m[ci] <= k_q;
      tfnum_m[ci] <= tf_q; tblk_m[ci] <= tb_q; phase_m[ci] <= ph_q; bnote_m[ci] <= bn_q;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        func_q <= func_i; ch_q <= channel_sel_i;
        note_q <= (note_value_i == 7'd0) ? 7'd1 : note_value_i;
        amt_q <= slide_amount_i; det_q <= pre_slide_i;
        a1_q <= arp_first_i; a2_q <= arp_second_i; vcnt_q <= vib_speed_i;
        div_q <= (vib_depth_i == 4'd0) ? 4'd0 :
                 (vib_depth_i > 4'd14) ? 4'd2 : 4'(5'd16 - {1'b0, vib_depth_i});
        if ({28'd0, channel_sel_i} < CHANNELS) begin
          f_q <= fnum_m[ld_ci];
          b_q <= blk_m[ld_ci];
          k_q <= key_m[ld_ci];
          tf_q <= tfnum_m[ld_ci];
          tb_q <= tblk_m[ld_ci];
          ph_q <= phase_m[ld_ci];
          bn_q <= bnote_m[ld_ci];
        end else begin
          f_q <= '0; b_q <= '0; k_q <= 1'b0; tf_q <= '0; tb_q <= '0; ph_q <= '0;
          bn_q <= '0;
        end
      end
      OP_NOTE_ON: begin
        bn_q <= note_q;
        if (note_q == NOTE_KEY_OFF) begin
          k_q <= 1'b0; tf_q <= f_q; tb_q <= b_q;
        end else begin
          k_q <= 1'b1; {b_q, f_q} <= r_nt; {tb_q, tf_q} <= r_nt;
        end
      end
      OP_SLIDE_UP: {b_q, f_q} <= r_up;
      OP_SLIDE_DN: {b_q, f_q} <= r_dn;
      OP_PORTA_TG: begin
        if (note_q == NOTE_KEY_OFF) {tb_q, tf_q} <= {b_q, f_q};
        else {tb_q, tf_q} <= r_tg;
      end
      OP_PORTA_UP: {b_q, f_q} <= (r_up > tgt_pos) ? tgt_pos : r_up;
      OP_PORTA_DN: {b_q, f_q} <= (r_dn < tgt_pos) ? tgt_pos : r_dn;
      OP_VIB_STEP: begin
        ph_q <= pn;
        {b_q, f_q} <= vup ? r_vu : r_vd;
        vcnt_q <= vcnt_q - 4'd1;
      end
      OP_ARP: begin
        if (a1_q != 4'd0 || a2_q != 4'd0) begin
          ph_q <= {4'd0, arp_p};
          if (arp_n != {1'b0, NOTE_KEY_OFF}) {b_q, f_q} <= r_ar;
          else k_q <= 1'b0;
        end
      end
      OP_KEY_OFF: k_q <= 1'b0;
      // output register: loaded only once the previous result has left
      OP_POST: begin
        lo_q <= chan_ok ? f_q[7:0] : 8'd0;
        bk_q <= chan_ok ? {k_q, b_q, f_q[9:8]} : 6'd0;
      end
      default: ;
    endcase
  end

  logic [3:0] oc_q;
  always_ff @(posedge clk_i) if (cmd_i.op == OP_POST) oc_q <= ch_q;
  assign out_channel_o = oc_q;
  assign fnum_low_o = lo_q;
  assign block_key_byte_o = bk_q;
endmodule

`default_nettype wire

@@ rtl/tracker_pitch_effect_unit_core.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tracker_pitch_effect_unit_core
// Pitch effects for FM channels, answering with frequency register bytes.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one command per transaction; m_axis returns one result
//   (channel, A0 byte, B0 byte) for every command.
//   Commands are taken one at a time: load, dispatch, store and output,
//   plus a second compare step for a portamento step and, for an active
//   vibrato, vib_speed phase steps (one phase step per cycle). A new
//   command is taken once the previous result is in the output register.
//   Reset clears all channel state at once; no clearing pass.
//   A result waits in the output register while m_axis_tready is low; the
//   next command may already be accepted and run, then holds in its last
//   step until the output register is free.
// ---------------------------------------------------------------------------
module tracker_pitch_effect_unit_core #(
  parameter int CHANNELS = 9
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // func[2:0] channel_sel[6:3] note_value[13:7] slide_amount[21:14]
  // pre_slide[29:22] vib_speed[33:30] vib_depth[37:34] arp_first[41:38]
  // arp_second[45:42]
  input  wire logic [47:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // out_channel[3:0] fnum_low[11:4] block_key_byte[17:12]
  output logic [23:0]      m_axis_tdata
);
  import tpe_pkg::*;

  tpe_cmd_t    cmd;
  tpe_status_t status;
  logic [3:0] oc;
  logic [7:0] lo;
  logic [5:0] bk;
  logic       pend;

  tpe_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(pend), .out_ready_i(m_axis_tready),
    .status_i(status), .cmd_o(cmd)
  );

  tpe_datapath #(.CHANNELS(CHANNELS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status),
    .func_i(s_axis_tdata[2:0]), .channel_sel_i(s_axis_tdata[6:3]),
    .note_value_i(s_axis_tdata[13:7]), .slide_amount_i(s_axis_tdata[21:14]),
    .pre_slide_i(s_axis_tdata[29:22]), .vib_speed_i(s_axis_tdata[33:30]),
    .vib_depth_i(s_axis_tdata[37:34]), .arp_first_i(s_axis_tdata[41:38]),
    .arp_second_i(s_axis_tdata[45:42]),
    .out_channel_o(oc), .fnum_low_o(lo), .block_key_byte_o(bk)
  );

  assign m_axis_tvalid = pend;
  assign m_axis_tdata  = {6'd0, bk, lo, oc};
endmodule

`default_nettype wire
